// File: rtl/lgr_pkg.sv
// ---------------------------------------------------------------------------
// Lagrange resampler package
// Shared constants, state encodings and the control struct of the resampler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgr_pkg;

  // Fraction bits of the interpolation offset and of the node coefficients.
  localparam int CF        = 24;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;
  localparam int MAX_OUT   = 32;
  localparam int CNT_W     = 6;
  localparam int NODES     = 5;

  // Width of the running node product; it never exceeds sixteen in Q.24.
  localparam int P_W  = 32;
  // Width of the second operand of the shared multiplier.
  localparam int MB_W = 33;

  // Reciprocal of three, exact for operands below two to the 31.
  localparam int               DIV3_SH    = 32;
  localparam logic [MB_W-1:0]  DIV3_MAGIC = 33'h055555556;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 16'sd16384;

  typedef enum logic {
    CFG_RATIO = 1'b0,
    CFG_GAIN  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MS_NODE,
    MS_DIV,
    MS_MAC,
    MS_GAIN
  } mul_sel_e;

  typedef enum logic [3:0] {
    ES_IDLE,
    ES_PMUL,
    ES_PSUB,
    ES_DPRE,
    ES_DMUL,
    ES_DFIN,
    ES_MMUL,
    ES_MACC,
    ES_VRND,
    ES_GMUL,
    ES_GFIN
  } eval_state_e;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_PASS,
    TS_UPCHK,
    TS_UPT,
    TS_PLAN,
    TS_EVAL,
    TS_LOAD
  } top_state_e;

  typedef struct packed {
    logic start;
    logic bypass;
  } eval_req_t;

endpackage

`default_nettype wire

// File: rtl/lgr_mul.sv
// ---------------------------------------------------------------------------
// Lagrange resampler shared multiplier
// Signed multiplier with a registered product, time-shared by the evaluator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgr_mul #(
  parameter int A_W = 33,
  parameter int B_W = 33
) (
  input  logic                     clk_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic signed [B_W-1:0]    b_i,
  output logic signed [A_W+B_W-1:0] p_o
);

  logic signed [A_W+B_W-1:0] p_d;
  logic signed [A_W+B_W-1:0] p_q;

  assign p_d = (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: rtl/lgr_eval.sv
// ---------------------------------------------------------------------------
// Lagrange resampler evaluator
// Sequencer computing one gain-scaled sample, interpolated unless bypassed, on
// one shared multiplier: node products, coefficient division, accumulation, gain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgr_eval #(
  parameter int SAMPLE_BITS   = 24,
  parameter int POS_FRAC_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lgr_pkg::eval_req_t                    req_i,
  output logic                                  done_o,
  input  logic [POS_FRAC_BITS:0]                t_i,
  input  logic signed [SAMPLE_BITS-1:0]         hist_i [lgr_pkg::NODES],
  input  logic signed [lgr_pkg::GAIN_W-1:0]     gain_i,
  output logic signed [SAMPLE_BITS-1:0]         result_o
);

  import lgr_pkg::*;

  localparam int TD    = (POS_FRAC_BITS > CF) ? POS_FRAC_BITS - CF : 0;
  localparam int TU    = (POS_FRAC_BITS < CF) ? CF - POS_FRAC_BITS : 0;
  localparam int TX_W  = POS_FRAC_BITS + CF + 1;
  localparam int V_W   = SAMPLE_BITS + 2;
  localparam int MA_W  = (V_W > P_W + 1) ? V_W : P_W + 1;
  localparam int PR_W  = MA_W + MB_W;
  localparam int W_W   = P_W + 3 + CF;
  localparam int ACC_W = SAMPLE_BITS + 32;
  localparam int Y_W   = P_W + 1;

  localparam logic signed [P_W-1:0]   ONE_P  = P_W'(1) <<< CF;
  localparam logic signed [W_W-1:0]   HALF_W = W_W'(1) <<< (CF - 1);
  localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) <<< (CF - 1);
  localparam logic signed [PR_W-1:0]  HALF_G = PR_W'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [PR_W-1:0]  SAT_HI = (PR_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [PR_W-1:0]  SAT_LO = -SAT_HI - 1;

  eval_state_e state_q, state_d;
  mul_sel_e    mul_sel;

  logic [2:0]                k_q, k_d;
  logic [2:0]                m_q, m_d;
  logic [2:0]                m_nx;
  logic signed [P_W-1:0]     p_q, p_d;
  logic [Y_W-1:0]            y_q, y_d;
  logic                      neg_q, neg_d;
  logic signed [Y_W-1:0]     coef_q, coef_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [V_W-1:0]     v_q, v_d;
  logic signed [SAMPLE_BITS-1:0] res_q, res_d;

  logic [TX_W-1:0]           t_ext;
  logic [CF:0]               t24;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PR_W-1:0]    prod;

  logic signed [P_W+2:0]     p_ext;
  logic signed [P_W+2:0]     cp;
  logic signed [W_W-1:0]     w_s;
  logic signed [W_W-1:0]     w_adj;
  logic signed [W_W-1:0]     w_r;
  logic signed [Y_W-1:0]     p_wide;
  logic [Y_W-1:0]            p_abs;
  logic [Y_W-1:0]            quot;
  logic signed [ACC_W-1:0]   a_adj;
  logic signed [ACC_W-1:0]   a_r;
  logic signed [PR_W-1:0]    g_adj;
  logic signed [PR_W-1:0]    g_r;
  logic signed [PR_W-1:0]    g_sat;

  // Offset reduced to 24 fraction bits.
  assign t_ext = TX_W'(t_i);
  assign t24   = (CF+1)'((t_ext >> TD) << TU);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (mul_sel)
      MS_NODE: begin
        mul_a = MA_W'(p_q);
        mul_b = MB_W'(t24);
      end
      MS_DIV: begin
        mul_a = MA_W'(y_q);
        mul_b = DIV3_MAGIC;
      end
      MS_MAC: begin
        mul_a = MA_W'(hist_i[3'(NODES-1) - k_q]);
        mul_b = MB_W'(coef_q);
      end
      MS_GAIN: begin
        mul_a = MA_W'(v_q);
        mul_b = MB_W'(gain_i);
      end
    endcase
  end

  lgr_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Next node index, skipping the node of the current coefficient.
  always_comb begin
    m_nx = m_q + 3'd1;
    if (m_nx == k_q) begin
      m_nx = m_nx + 3'd1;
    end
  end

  // Node difference times p is (m-2)*p*2^24 - p*t, rounded back to Q.24.
  always_comb begin
    p_ext = (P_W+3)'(p_q);
    unique case (m_q)
      3'd0:    cp = -(p_ext <<< 1);
      3'd1:    cp = -p_ext;
      3'd3:    cp = p_ext;
      3'd4:    cp = p_ext <<< 1;
      default: cp = '0;
    endcase
    w_s   = (W_W'(cp) <<< CF) - W_W'(prod);
    w_adj = w_s[W_W-1] ? HALF_W - 1 : HALF_W;
    w_r   = w_s + w_adj;
  end

  // Coefficient division by node constant; all rounding away from zero; saturation.
  always_comb begin
    p_wide = Y_W'(p_q);
    p_abs  = p_wide[Y_W-1] ? Y_W'(-p_wide) : Y_W'(p_wide);
    quot   = (k_q == 3'd2) ? y_q : Y_W'(prod >>> DIV3_SH);
    a_adj  = acc_q[ACC_W-1] ? HALF_A - 1 : HALF_A;
    a_r    = acc_q + a_adj;
    g_adj  = prod[PR_W-1] ? HALF_G - 1 : HALF_G;
    g_r    = (prod + g_adj) >>> GAIN_FRAC;
    if (g_r > SAT_HI) begin
      g_sat = SAT_HI;
    end else if (g_r < SAT_LO) begin
      g_sat = SAT_LO;
    end else begin
      g_sat = g_r;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ES_IDLE: begin
        if (req_i.start) begin
          state_d = req_i.bypass ? ES_GMUL : ES_PMUL;
        end
      end
      ES_PMUL: state_d = ES_PSUB;
      ES_PSUB: state_d = (m_nx > 3'd4) ? ES_DPRE : ES_PMUL;
      ES_DPRE: state_d = ES_DMUL;
      ES_DMUL: state_d = ES_DFIN;
      ES_DFIN: state_d = ES_MMUL;
      ES_MMUL: state_d = ES_MACC;
      ES_MACC: state_d = (k_q == 3'd4) ? ES_VRND : ES_PMUL;
      ES_VRND: state_d = ES_GMUL;
      ES_GMUL: state_d = ES_GFIN;
      ES_GFIN: state_d = ES_IDLE;
      default: state_d = ES_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    mul_sel = MS_NODE;
    done_o  = 1'b0;
    k_d     = k_q;
    m_d     = m_q;
    p_d     = p_q;
    y_d     = y_q;
    neg_d   = neg_q;
    coef_d  = coef_q;
    acc_d   = acc_q;
    v_d     = v_q;
    res_d   = res_q;
    unique case (state_q)
      ES_IDLE: begin
        if (req_i.start) begin
          k_d   = 3'd0;
          m_d   = 3'd1;
          p_d   = ONE_P;
          acc_d = '0;
          v_d   = V_W'(hist_i[0]);
        end
      end
      ES_PMUL: mul_sel = MS_NODE;
      ES_PSUB: begin
        p_d = P_W'(w_r >>> CF);
        m_d = m_nx;
      end
      ES_DPRE: begin
        // Divisors are 24 for the outer nodes, -6 next to them, 4 in the centre.
        neg_d = p_q[P_W-1] ^ ((k_q == 3'd1) || (k_q == 3'd3));
        if ((k_q == 3'd0) || (k_q == 3'd4)) begin
          y_d = (p_abs + Y_W'(12)) >> 3;
        end else if (k_q == 3'd2) begin
          y_d = (p_abs + Y_W'(2)) >> 2;
        end else begin
          y_d = (p_abs + Y_W'(3)) >> 1;
        end
      end
      ES_DMUL: mul_sel = MS_DIV;
      ES_DFIN: coef_d = neg_q ? -$signed(quot) : $signed(quot);
      ES_MMUL: mul_sel = MS_MAC;
      ES_MACC: begin
        acc_d = acc_q + ACC_W'(prod);
        if (k_q != 3'd4) begin
          k_d = k_q + 3'd1;
          m_d = 3'd0;
          p_d = ONE_P;
        end
      end
      ES_VRND: v_d = V_W'(a_r >>> CF);
      ES_GMUL: mul_sel = MS_GAIN;
      ES_GFIN: begin
        res_d  = SAMPLE_BITS'(g_sat);
        done_o = 1'b1;
      end
      default: mul_sel = MS_NODE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ES_IDLE;
      k_q     <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      m_q     <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    y_q    <= y_d;
    neg_q  <= neg_d;
    coef_q <= coef_d;
    acc_q  <= acc_d;
    v_q    <= v_d;
    res_q  <= res_d;
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

// File: rtl/lagrange_resampler.sv
// ---------------------------------------------------------------------------
// Lagrange resampler
// Sample-rate converter with five-point fourth-order Lagrange interpolation,
// gain and saturation, built around one shared multiplier.
// ---------------------------------------------------------------------------
//  channel   direction  fields (lowest bit first)
//  s_axis    in         tdata: in_sample
//  m_axis    out        tdata: out_sample, tlast: last_of_run
//  cfg       in         index 0 ratio, index 1 gain
//
// A result is computed on one multiplier: five coefficients in turn, each from
// four node products, a division and an accumulation, then rounding and gain.
// An input item yields up to 32 results below a ratio of one, at most one above
// it and exactly one at one; a new item is taken only while the sequencer idles.
// Reset (asynchronous, active low) restores ratio and gain 1.0, a zero
// history and a read position of 1.0. A stalled result holds the sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lagrange_resampler #(
  parameter int SAMPLE_BITS   = 24,
  parameter int POS_FRAC_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // in_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_sample
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [POS_FRAC_BITS+4:0]             cfg_data_i
);

  import lgr_pkg::*;

  localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int POS_BITS = POS_FRAC_BITS + 5;

  localparam logic [POS_BITS-1:0]      POS_ONE = POS_BITS'(1) << POS_FRAC_BITS;
  localparam logic [POS_FRAC_BITS:0]   T_ONE   = (POS_FRAC_BITS+1)'(1) << POS_FRAC_BITS;

  top_state_e state_q, state_d;
  eval_req_t  req;
  logic       eval_done;
  logic signed [SAMPLE_BITS-1:0] eval_res;

  logic [POS_BITS-1:0]           ratio_q, ratio_d;
  logic signed [GAIN_W-1:0]      gain_q, gain_d;
  logic signed [SAMPLE_BITS-1:0] hist_q [NODES];
  logic signed [SAMPLE_BITS-1:0] hist_d [NODES];
  logic [POS_BITS-1:0]           pos_q, pos_d;
  logic [POS_FRAC_BITS:0]        t_q, t_d;
  logic [CNT_W-1:0]              n_q, n_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]        out_data_q, out_data_d;
  logic                          out_last_q, out_last_d;

  logic                          ratio_one;
  logic                          ratio_below;
  logic                          pos_below;
  logic [POS_BITS:0]             pos_inc;
  logic [POS_BITS-1:0]           pos_add;
  logic                          out_free;

  assign ratio_one   = (ratio_q == POS_ONE);
  assign ratio_below = (ratio_q[POS_BITS-1:POS_FRAC_BITS] == '0);
  assign pos_below   = (pos_q[POS_BITS-1:POS_FRAC_BITS] == '0);
  assign pos_inc     = {1'b0, pos_q} + {1'b0, POS_ONE};
  assign pos_add     = pos_q + ratio_q;
  assign out_free    = !out_valid_q || m_axis_tready;

  lgr_eval #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .done_o   (eval_done),
    .t_i      (t_q),
    .hist_i   (hist_q),
    .gain_i   (gain_q),
    .result_o (eval_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TS_IDLE: begin
        if (s_axis_tvalid) begin
          if (ratio_one) begin
            state_d = TS_PASS;
          end else if (ratio_below) begin
            state_d = TS_PLAN;
          end else begin
            state_d = TS_UPCHK;
          end
        end
      end
      TS_PASS:  state_d = TS_EVAL;
      TS_UPCHK: state_d = (pos_q >= ratio_q) ? TS_UPT : TS_IDLE;
      TS_UPT:   state_d = TS_EVAL;
      TS_PLAN:  state_d = (pos_below && !n_q[CNT_W-1]) ? TS_EVAL : TS_IDLE;
      TS_EVAL:  state_d = eval_done ? TS_LOAD : TS_EVAL;
      TS_LOAD: begin
        if (out_free) begin
          state_d = last_q ? TS_IDLE : TS_PLAN;
        end
      end
      default:  state_d = TS_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    s_axis_tready = 1'b0;
    req           = '0;
    ratio_d       = ratio_q;
    gain_d        = gain_q;
    hist_d        = hist_q;
    pos_d         = pos_q;
    t_d           = t_q;
    n_d           = n_q;
    last_d        = last_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RATIO: ratio_d = cfg_data_i[POS_BITS-1:0];
        CFG_GAIN:  gain_d  = cfg_data_i[GAIN_W-1:0];
      endcase
    end

    unique case (state_q)
      TS_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          for (int i = NODES - 1; i > 0; i--) begin
            hist_d[i] = hist_q[i-1];
          end
          hist_d[0] = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
          n_d = '0;
          if (ratio_one) begin
            pos_d = pos_q;
          end else if (ratio_below) begin
            pos_d = pos_below ? '0 : pos_q - POS_ONE;
          end else begin
            pos_d = pos_inc[POS_BITS] ? '1 : pos_inc[POS_BITS-1:0];
          end
        end
      end
      TS_PASS: begin
        last_d     = 1'b1;
        req.start  = 1'b1;
        req.bypass = 1'b1;
      end
      TS_UPCHK: begin
        if (pos_q >= ratio_q) begin
          pos_d = pos_q - ratio_q;
        end
      end
      TS_UPT: begin
        // A stale position of one or more gives offset zero.
        t_d       = pos_below ? T_ONE - (POS_FRAC_BITS+1)'(pos_q) : '0;
        last_d    = 1'b1;
        req.start = 1'b1;
      end
      TS_PLAN: begin
        if (pos_below && !n_q[CNT_W-1]) begin
          t_d       = (POS_FRAC_BITS+1)'(pos_q);
          pos_d     = pos_add;
          n_d       = n_q + CNT_W'(1);
          last_d    = (pos_add[POS_BITS-1:POS_FRAC_BITS] != '0) ||
                      (n_q >= CNT_W'(MAX_OUT - 1));
          req.start = 1'b1;
        end
      end
      TS_EVAL: req.start = 1'b0;
      TS_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = eval_res;
          out_last_d  = last_q;
        end
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TS_IDLE;
      ratio_q     <= POS_ONE;
      gain_q      <= GAIN_RESET;
      hist_q      <= '{default: '0};
      pos_q       <= POS_ONE;
      n_q         <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ratio_q     <= ratio_d;
      gain_q      <= gain_d;
      hist_q      <= hist_d;
      pos_q       <= pos_d;
      n_q         <= n_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/lgr_checker.sv
// ---------------------------------------------------------------------------
// Lagrange resampler port checker
// Concurrent checks on the stream ports of the resampler, bound to the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgr_checker #(
  parameter int TDATA_W = 24
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tlast
);

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // One request at a time: the input closes right after a request is taken.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open again right after a request");

  // While a run is still incomplete no new input may be taken.
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open in the middle of a run");

endmodule

bind lagrange_resampler lgr_checker #(
  .TDATA_W (TDATA_W)
) u_lgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: tb/resampler_checker.sv
// ---------------------------------------------------------------------------
// Lagrange resampler checker
// Watches the sample, result and configuration channels of the resampler.
// It keeps its own copy of the history, read position, ratio and gain, and
// works out the results of every accepted sample. Each accepted result is
// compared with the oldest one still outstanding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module resampler_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // in_sample
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_sample
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [28:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  import lgr_pkg::*;

  localparam longint ONE_POS  = 64'd16777216;
  localparam longint POS_MAX  = 64'd536870911;
  localparam longint SAMP_MAX = 64'sd8388607;
  localparam longint SAMP_MIN = -64'sd8388608;

  typedef struct packed {
    logic [23:0] sample;
    logic        last;
  } out_item_t;

  out_item_t          expected_outputs [$];
  logic [28:0]        ratio_q;
  logic signed [15:0] gain_q;
  logic [28:0]        read_pos;
  longint             hist [5];
  int                 n_errors;

  // Rounds half away from zero while shifting right.
  function automatic longint round_shift(longint v, int s);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint round_div(longint v, longint d);
    longint num;
    longint den;
    longint mag;
    num = (d < 0) ? -v : v;
    den = (d < 0) ? -d : d;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // Lagrange value at offset t (Q.24), with the oldest sample at node -2.
  function automatic longint interpolate(longint t);
    longint acc;
    longint p;
    longint den;
    int     k;
    int     m;
    acc = 0;
    for (k = 0; k < NODES; k++) begin
      p = ONE_POS;
      for (m = 0; m < NODES; m++) begin
        if (m != k) p = round_shift(p * ((m - 2) * ONE_POS - t), CF);
      end
      case (k)
        0, 4:    den = 24;
        1, 3:    den = -6;
        default: den = 4;
      endcase
      acc += round_div(p, den) * hist[4 - k];
    end
    return round_shift(acc, CF);
  endfunction

  function automatic logic [23:0] scale_saturate(longint v);
    longint r;
    r = round_shift(v * longint'(gain_q), GAIN_FRAC);
    if (r > SAMP_MAX) r = SAMP_MAX;
    if (r < SAMP_MIN) r = SAMP_MIN;
    return r[23:0];
  endfunction

  task automatic resample_step(input logic [23:0] s);
    longint    pos;
    longint    t;
    int        n;
    out_item_t item;
    pos = longint'(read_pos);
    n   = 0;
    for (int i = 4; i > 0; i--) hist[i] = hist[i - 1];
    hist[0] = longint'($signed(s));
    if (longint'(ratio_q) == ONE_POS) begin
      item.sample = scale_saturate(hist[0]);
      item.last   = 1'b1;
      expected_outputs.push_back(item);
    end else if (longint'(ratio_q) < ONE_POS) begin
      pos = (pos >= ONE_POS) ? pos - ONE_POS : 0;
      while (pos < ONE_POS && n < MAX_OUT) begin
        item.sample = scale_saturate(interpolate(pos));
        item.last   = 1'b0;
        expected_outputs.push_back(item);
        pos += longint'(ratio_q);
        n++;
      end
      if (n > 0) begin
        item      = expected_outputs.pop_back();
        item.last = 1'b1;
        expected_outputs.push_back(item);
      end
      read_pos = pos[28:0];
    end else begin
      pos = (POS_MAX - pos < ONE_POS) ? POS_MAX : pos + ONE_POS;
      if (pos >= longint'(ratio_q)) begin
        pos -= longint'(ratio_q);
        t = (pos >= ONE_POS) ? 0 : ONE_POS - pos;
        item.sample = scale_saturate(interpolate(t));
        item.last   = 1'b1;
        expected_outputs.push_back(item);
      end
      read_pos = pos[28:0];
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      ratio_q  = 29'd16777216;
      gain_q   = GAIN_RESET;
      read_pos = 29'd16777216;
      for (int i = 0; i < NODES; i++) hist[i] = 0;
      expected_outputs.delete();
      n_errors  = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RATIO) ratio_q = cfg_data_i;
        else                        gain_q  = cfg_data_i[15:0];
      end
      if (s_axis_tvalid && s_axis_tready) resample_step(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected result: expected none, got out_sample %0d last %0b",
                   $time, $signed(m_axis_tdata), m_axis_tlast);
          n_errors++;
        end else begin
          want = expected_outputs.pop_front();
          if (m_axis_tdata !== want.sample) begin
            $display("%0t: out_sample mismatch: expected %0d, got %0d",
                     $time, $signed(want.sample), $signed(m_axis_tdata));
            n_errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                     $time, want.last, m_axis_tlast);
            n_errors++;
          end
        end
      end
      pending_o <= expected_outputs.size();
      errors_o  <= n_errors;
    end
  end

endmodule

// File: tb/testbench.sv
// ---------------------------------------------------------------------------
// Lagrange resampler testbench
// Drives samples and register writes into the resampler: a short directed
// part over the ratio modes, gain extremes and corner cases, then random
// phases with a fresh ratio and gain each. Both channels idle at random.
// The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lgr_pkg::*;

  localparam logic [28:0] RATIO_ONE = 29'd16777216;
  localparam logic [28:0] RATIO_TOP = 29'd268435456;
  // Generous margin for a block finishing a request that yields no result.
  localparam int SETTLE = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [28:0] cfg_data_i;
  logic        idle_on;
  int          stall_left = 0;
  int          pending;
  int          errors;

  lagrange_resampler DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  resampler_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side back-pressure: stall bursts that start at random while idle_on is set.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) m_axis_tready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(1, 9);
    end
  end

  function automatic logic [23:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return {16'h0000, r[7:0]};
      3:       return {16'hFFFF, r[7:0]};
      default: return r[23:0];
    endcase
  endfunction

  // Both registers are written back to back, ratio first.
  task automatic set_config(input logic [28:0] ratio, input logic [15:0] gain);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RATIO;
    cfg_data_i <= ratio;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GAIN;
    cfg_data_i <= {13'd0, gain};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Valid stays high between back-to-back requests; it drops for a gap or a drain.
  task automatic send_sample(input logic [23:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // The checker's count is registered, hence the first wait.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int          rand_items;
    int          phase_len;
    logic [28:0] ratio;
    logic [15:0] gain;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_RATIO;
    cfg_data_i    = '0;
    idle_on       = 1'b1;
    rand_items    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pass-through at reset settings, then the gain extremes with saturation.
    send_sample(24'h7FFFFF);
    send_sample(24'h800000);
    send_sample(24'h000000);
    send_sample(24'hFFFFFF);
    drain();
    set_config(RATIO_ONE, 16'h8000);
    send_sample(24'h800000);
    send_sample(24'h7FFFFF);
    drain();
    // Ratio zero and a ratio under one thirty-second: the output count caps.
    set_config(29'd0, 16'h7FFF);
    send_sample(24'h7FFFFF);
    drain();
    set_config(29'd400000, 16'h7FFF);
    send_sample(24'h800000);
    drain();
    set_config(29'd524288, 16'd16384);
    send_sample(pick_sample());
    drain();
    // A large ratio builds up the position; a small one above unity then
    // drains it at offset zero.
    set_config(RATIO_TOP, 16'd16384);
    repeat (3) send_sample(pick_sample());
    drain();
    set_config(29'd20971520, 16'd16384);
    repeat (3) send_sample(pick_sample());
    drain();
    // Below unity from a position still above one: no results until it falls under one.
    set_config(29'd12582912, 16'd16384);
    repeat (3) send_sample(pick_sample());
    drain();
    set_config(RATIO_ONE + 29'd1, 16'h1000);
    repeat (2) send_sample(pick_sample());
    drain();
    set_config(RATIO_ONE - 29'd1, 16'h0000);
    repeat (2) send_sample(pick_sample());
    drain();

    while (rand_items < 72) begin
      case ($urandom_range(0, 9))
        0:       ratio = RATIO_ONE;
        1:       ratio = 29'($urandom_range(0, 524287));
        2, 3, 4: ratio = 29'($urandom_range(4194304, 16777215));
        5:       ratio = 29'($urandom_range(524288, 4194303));
        6, 7, 8: ratio = 29'($urandom_range(16777217, 67108864));
        default: ratio = $urandom_range(0, 1) ? RATIO_TOP
                                              : 29'($urandom_range(67108864, 268435456));
      endcase
      case ($urandom_range(0, 5))
        0:       gain = 16'h8000;
        1:       gain = 16'h7FFF;
        2, 3:    gain = 16'($urandom_range(0, 65535));
        default: gain = 16'($urandom_range(15360, 17408));
      endcase
      idle_on <= (rand_items < 54) && ($urandom_range(0, 4) != 0);
      set_config(ratio, gain);
      phase_len = $urandom_range(4, 16);
      repeat (phase_len) send_sample(pick_sample());
      rand_items += phase_len;
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("PASS lagrange_resampler");
    end else begin
      $display("FAIL lagrange_resampler");
    end
    $finish;
  end

  // Worst case is about 115 requests of 32 results each; this allows several
  // times as long as that takes.
  initial begin
    #40000000;
    $display("FAIL lagrange_resampler");
    $finish;
  end

endmodule

// File: sim.f
rtl/lgr_pkg.sv
rtl/lgr_mul.sv
rtl/lgr_eval.sv
rtl/lagrange_resampler.sv
rtl/lgr_checker.sv
tb/resampler_checker.sv
tb/testbench.sv
